// ===== hdl/p3lt_pkg.sv =====
// Package for the POP3 line, command and reply tracker.
// Holds the character codes, command and event codes, and the types
// shared by the front end, the top level and the session back end.
package p3lt_pkg;

   localparam int MAX_PENDING_DEFAULT = 255;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   // Words are stored with the first character in the low byte.
   localparam logic [31:0] WORD_USER = 32'h7265_7375;
   localparam logic [31:0] WORD_RETR = 32'h7274_6572;
   localparam logic [23:0] WORD_OK   = 24'h6B_6F2B;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_USER  = 2'd1,
      CMD_RETR  = 2'd2,
      CMD_OTHER = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      EVT_NONE      = 2'd0,
      EVT_PIPELINED = 2'd1,
      EVT_FULL      = 2'd2
   } evt_code_type;

   typedef struct packed {
      logic    direction;
      logic    line_end;
      cmd_type cls;
      logic    is_ok;
      logic    is_dot;
   } line_item_type;

   typedef struct packed {
      logic         line_end;
      cmd_type      command_class;
      logic         data_mode;
      logic         body_line;
      logic         message_end;
      logic         mime_start;
      logic         new_transaction;
      logic [15:0]  transaction_id;
      evt_code_type event_code;
      logic [7:0]   pending_commands;
   } result_type;

   function automatic logic [31:0] lower_word(input logic [31:0] word);
      logic [31:0] res;
      res = word;
      for (int i = 0; i < 4; i++) begin
         if (word[8*i +: 8] >= 8'h41 && word[8*i +: 8] <= 8'h5A) begin
            res[8*i +: 8] = word[8*i +: 8] + 8'h20;
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/p3lt_req_if.sv =====
// Input channel of the POP3 tracker: one stream byte and its direction.
// Depends on nothing; used by the top level and the front end.
interface p3lt_req_if;
   logic       valid;
   logic       ready;
   logic       direction;
   logic [7:0] data_byte;

   modport source (output valid, output direction, output data_byte, input ready);
   modport sink (input valid, input direction, input data_byte, output ready);
endinterface

// ===== hdl/p3lt_rsp_if.sv =====
// Result channel of the POP3 tracker: one result per input byte.
// Depends on nothing; used by the top level and the back end.
interface p3lt_rsp_if;
   logic        valid;
   logic        ready;
   logic        line_end;
   logic [1:0]  command_class;
   logic        data_mode;
   logic        body_line;
   logic        message_end;
   logic        mime_start;
   logic        new_transaction;
   logic [15:0] transaction_id;
   logic [1:0]  event_code;
   logic [7:0]  pending_commands;

   modport source (output valid, output line_end, output command_class,
                   output data_mode, output body_line, output message_end,
                   output mime_start, output new_transaction,
                   output transaction_id, output event_code,
                   output pending_commands, input ready);
   modport sink (input valid, input line_end, input command_class,
                 input data_mode, input body_line, input message_end,
                 input mime_start, input new_transaction,
                 input transaction_id, input event_code,
                 input pending_commands, output ready);
endinterface

// ===== hdl/p3lt_front.sv =====
// Front end: splits each direction into lines and classifies each line.
// Depends on p3lt_pkg and p3lt_req_if; pushes one item per byte into the queue.
module p3lt_front (
   input  logic                   clock,
   input  logic                   reset,
   p3lt_req_if.sink               req,
   input  logic                   queue_full,
   output logic                   queue_push,
   output p3lt_pkg::line_item_type queue_item
);
   import p3lt_pkg::*;

   logic [2:0]  count_ff [2];
   logic [2:0]  count_in [2];
   logic [31:0] prefix_ff [2];
   logic [31:0] prefix_in [2];
   logic        cr_ff [2];
   logic        cr_in [2];

   logic        dir;
   logic [7:0]  byte_val;
   logic [2:0]  cur_count;
   logic [31:0] cur_prefix;
   logic [31:0] low_prefix;
   logic [2:0]  len;
   logic        is_lf;

   assign req.ready  = !reset && !queue_full;
   assign queue_push = req.valid && req.ready;

   assign dir        = req.direction;
   assign byte_val   = req.data_byte;
   assign cur_count  = count_ff[dir];
   assign cur_prefix = prefix_ff[dir];
   assign low_prefix = lower_word(cur_prefix);
   assign is_lf      = (byte_val == CHAR_LF);
   assign len        = (cr_ff[dir] && cur_count != 3'd0) ? cur_count - 3'd1 : cur_count;

   always_comb begin
      queue_item.direction = dir;
      queue_item.line_end  = is_lf;
      queue_item.is_ok     = (len >= 3'd3) && (low_prefix[23:0] == WORD_OK);
      queue_item.is_dot    = (len == 3'd1) && (cur_prefix[7:0] == CHAR_DOT);
      priority if ((len >= 3'd4) && (low_prefix == WORD_USER)) begin
         queue_item.cls = CMD_USER;
      end else if ((len >= 3'd4) && (low_prefix == WORD_RETR)) begin
         queue_item.cls = CMD_RETR;
      end else begin
         queue_item.cls = CMD_OTHER;
      end
   end

   always_comb begin
      for (int d = 0; d < 2; d++) begin
         count_in[d]  = count_ff[d];
         prefix_in[d] = prefix_ff[d];
         cr_in[d]     = cr_ff[d];
      end
      if (queue_push) begin
         if (is_lf) begin
            count_in[dir]  = 3'd0;
            prefix_in[dir] = 32'd0;
            cr_in[dir]     = 1'b0;
         end else begin
            if (cur_count < 3'd4) begin
               prefix_in[dir][8*cur_count[1:0] +: 8] = byte_val;
            end
            if (cur_count < 3'd7) begin
               count_in[dir] = cur_count + 3'd1;
            end
            cr_in[dir] = (byte_val == CHAR_CR);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < 2; d++) begin
            count_ff[d]  <= 3'd0;
            prefix_ff[d] <= 32'd0;
            cr_ff[d]     <= 1'b0;
         end
      end else begin
         for (int d = 0; d < 2; d++) begin
            count_ff[d]  <= count_in[d];
            prefix_ff[d] <= prefix_in[d];
            cr_ff[d]     <= cr_in[d];
         end
      end
   end

endmodule

// ===== hdl/p3lt_fifo.sv =====
// Short queue between the front end and the back end.
// Generic width and depth; registers only, read at the head pointer.
module p3lt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (fill_ff == CW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/p3lt_back.sv =====
// Back end: session state, command counting, data mode and the output register.
// Depends on p3lt_pkg and p3lt_rsp_if; takes classified items from the queue.
module p3lt_back #(
   parameter int MAX_PENDING = p3lt_pkg::MAX_PENDING_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  p3lt_pkg::line_item_type item,
   output logic                   item_pop,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data,
   p3lt_rsp_if.source             rsp
);
   import p3lt_pkg::*;

   localparam int PW = $clog2(MAX_PENDING + 1);
   localparam int SW = (PW > 8) ? PW : 8;

   logic        mime_ff;
   logic        body_ff, body_in;
   cmd_type     last_ff, last_in;
   logic [PW-1:0] pending_ff, pending_in;
   logic [PW-1:0] matched_ff, matched_in;
   logic        open_ff, open_in;
   logic [15:0] tx_ff, tx_in;
   logic        out_valid_ff;
   result_type  out_ff, out_in;
   logic [PW:0] matched_inc;
   logic [SW-1:0] pending_wide;

   assign csr_ready   = !reset;
   assign item_pop    = item_valid && (!out_valid_ff || rsp.ready);
   assign matched_inc = {1'b0, matched_ff} + {{PW{1'b0}}, 1'b1};

   always_comb begin
      body_in    = body_ff;
      last_in    = last_ff;
      pending_in = pending_ff;
      matched_in = matched_ff;
      open_in    = open_ff;
      tx_in      = tx_ff;
      out_in.line_end        = item.line_end;
      out_in.body_line       = 1'b0;
      out_in.message_end     = 1'b0;
      out_in.mime_start      = 1'b0;
      out_in.new_transaction = 1'b0;
      out_in.event_code      = EVT_NONE;
      if (item.line_end) begin
         if (!item.direction) begin
            if (!open_ff) begin
               open_in = 1'b1;
               tx_in   = tx_ff + 16'd1;
               out_in.new_transaction = 1'b1;
            end
            if (!body_ff) begin
               last_in = item.cls;
               out_in.mime_start = (item.cls == CMD_RETR) && mime_ff;
               if (pending_ff >= PW'(MAX_PENDING)) begin
                  out_in.event_code = EVT_FULL;
               end else begin
                  pending_in = pending_ff + PW'(1);
                  if (pending_ff != '0) begin
                     out_in.event_code = EVT_PIPELINED;
                  end
               end
            end
         end else begin
            if (last_ff == CMD_RETR) begin
               if (body_ff) begin
                  if (item.is_dot) begin
                     body_in = 1'b0;
                     open_in = 1'b0;
                     out_in.message_end = 1'b1;
                  end else begin
                     out_in.body_line = mime_ff;
                  end
               end else if (item.is_ok) begin
                  body_in = 1'b1;
               end
            end
            if (matched_inc >= {1'b0, pending_ff}) begin
               matched_in = '0;
               pending_in = '0;
            end else begin
               matched_in = matched_inc[PW-1:0];
            end
         end
      end
      pending_wide = SW'(pending_in);
      out_in.command_class    = last_in;
      out_in.data_mode        = body_in;
      out_in.transaction_id   = tx_in - 16'd1;
      out_in.pending_commands = (pending_wide > SW'(255)) ? 8'hFF : pending_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mime_ff      <= 1'b0;
         body_ff      <= 1'b0;
         last_ff      <= CMD_NONE;
         pending_ff   <= '0;
         matched_ff   <= '0;
         open_ff      <= 1'b0;
         tx_ff        <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mime_ff <= csr_data;
         end
         if (item_pop) begin
            body_ff    <= body_in;
            last_ff    <= last_in;
            pending_ff <= pending_in;
            matched_ff <= matched_in;
            open_ff    <= open_in;
            tx_ff      <= tx_in;
         end
         if (item_pop) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.line_end         = out_ff.line_end;
   assign rsp.command_class    = out_ff.command_class;
   assign rsp.data_mode        = out_ff.data_mode;
   assign rsp.body_line        = out_ff.body_line;
   assign rsp.message_end      = out_ff.message_end;
   assign rsp.mime_start       = out_ff.mime_start;
   assign rsp.new_transaction  = out_ff.new_transaction;
   assign rsp.transaction_id   = out_ff.transaction_id;
   assign rsp.event_code       = out_ff.event_code;
   assign rsp.pending_commands = out_ff.pending_commands;

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PW'(MAX_PENDING))
      else $error("pending command count above its limit");

   a_matched_below: assert property (@(posedge clock) disable iff (reset)
      matched_ff < pending_ff || (matched_ff == '0 && pending_ff == '0))
      else $error("matched replies caught up with pending commands");

   a_end_leaves_body: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.message_end |-> !out_ff.data_mode && !out_ff.body_line)
      else $error("message end reported while still in data mode");

   a_body_needs_mime: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.body_line |-> out_ff.data_mode && mime_ff)
      else $error("body line reported outside data mode or without MIME");

endmodule

// ===== hdl/pop3_line_command_reply_tracker.sv =====
// POP3 line, command and reply tracker, top level.
// Depends on p3lt_pkg, p3lt_req_if, p3lt_rsp_if, p3lt_front, p3lt_fifo, p3lt_back.
//
// Usage:
// req_ch carries one stream byte per transfer, tagged with its direction
// (0 client to server, 1 server to client). rsp_ch returns exactly one
// result per input byte, in order, describing the session state after it.
// The csr port writes mime_enable; it is ready whenever reset is low and
// should be written only while no bytes are in flight.
// A transferred byte is written into the queue, and its result is registered
// in the output register before it appears on rsp_ch. Throughput is one byte
// per cycle while rsp_ch.ready stays high; the back end updates its session registers per byte.
// The front end splits lines and classifies them; a queue of QUEUE_DEPTH
// entries and the output register decouple it from the back end. When the
// receiver stalls, the output register holds its result, the queue fills,
// and req_ch.ready drops once the queue is full.
// Synchronous reset clears all line, command and transaction state and sets
// mime_enable to 0; no transfer is taken while reset is high.
module pop3_line_command_reply_tracker #(
   parameter int MAX_PENDING = p3lt_pkg::MAX_PENDING_DEFAULT,
   parameter int QUEUE_DEPTH = p3lt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   p3lt_req_if.sink   req_ch,
   p3lt_rsp_if.source rsp_ch,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);
   import p3lt_pkg::*;

   localparam int IW = $bits(line_item_type);

   logic          queue_full;
   logic          queue_empty;
   logic          queue_push;
   logic          queue_pop;
   line_item_type push_item;
   line_item_type head_item;
   logic [IW-1:0] head_bits;

   p3lt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_item (push_item)
   );

   p3lt_fifo #(
      .WIDTH (IW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_item),
      .pop       (queue_pop),
      .head_data (head_bits),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign head_item = line_item_type'(head_bits);

   p3lt_back #(
      .MAX_PENDING (MAX_PENDING)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_empty),
      .item       (head_item),
      .item_pop   (queue_pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp        (rsp_ch)
   );

endmodule
